// ----- rtl/rrss_pkg.sv -----
`default_nettype none

package rrss_pkg;

	localparam int unsigned TIME_W   = 64;
	localparam int unsigned PID_W    = 32;
	localparam int unsigned IDX_W    = 4;
	localparam int unsigned STATUS_W = 3;

	// Event kinds carried on the request side.
	typedef enum logic [1:0] {
		KIND_YIELD  = 2'd0,
		KIND_CREATE = 2'd1,
		KIND_EXIT   = 2'd2,
		KIND_SLEEP  = 2'd3
	} kind_t;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		STAT_OK        = 3'd0,
		STAT_NONE_RDY  = 3'd1,
		STAT_FULL      = 3'd2,
		STAT_EMPTY     = 3'd3,
		STAT_LAST_EXIT = 3'd4
	} status_t;

	// Operation of the shared 64-bit adder.
	typedef enum logic {
		ALU_ADD = 1'b0,
		ALU_SUB = 1'b1
	} alu_op_t;

endpackage

`default_nettype wire

// ----- rtl/rrss_ram.sv -----
`default_nettype none

module rrss_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

// ----- rtl/rrss_alu.sv -----
`default_nettype none

module rrss_alu (
	input  wire rrss_pkg::alu_op_t                op,
	input  wire logic [rrss_pkg::TIME_W-1:0]      a,
	input  wire logic [rrss_pkg::TIME_W-1:0]      b,
	output logic      [rrss_pkg::TIME_W-1:0]      sum,
	output logic                                  ge
);

	import rrss_pkg::*;

	logic          sub;
	logic [TIME_W:0] full;

	// One adder serves both the deadline sum and the unsigned a >= b test:
	// for a subtract the carry out is set exactly when no borrow occurs.
	assign sub  = (op == ALU_SUB);
	assign full = {1'b0, a} + {1'b0, (sub ? ~b : b)} + (TIME_W + 1)'(sub);
	assign sum  = full[TIME_W-1:0];
	assign ge   = full[TIME_W];

endmodule

`default_nettype wire

// ----- rtl/round_robin_sleep_scheduler_core.sv -----
`default_nettype none

// Round robin thread scheduler with sleep deadlines. The block keeps a compact
// table of up to MAX_THREADS threads, each holding a pid and a 64-bit wake
// deadline, together with the thread count, the running index and a pid
// counter. Each request names a kind (on s_tuser) and the current time, plus a
// sleep length for a sleep request. A yield scans round robin from the entry
// after the running one and picks the first entry whose deadline is at or
// before the current time; a sleep first sets the running entry's deadline to
// now + sleep_ticks (modulo 2^64) and then yields. A create appends a thread
// with the next pid and a deadline of zero, unless the table is full. An exit
// moves the highest entry into the hole, unless it is the exiting entry itself,
// and picks the next index. Every request yields exactly one result with a
// status, the running index, the running pid and the new pid. The block works
// on one request at a time and drops s_tready while busy. A yield, sleep or
// exit on an empty table goes straight to the result. A yield's scan stops at
// the first ready entry, and a sleep first writes the deadline, so the slowest
// request is a sleep on a full table that finds nothing ready. A result still
// waiting in the output register holds the block in its final state until it
// is taken. The scan is set by the single read port of the deadline memory,
// which delivers one entry per cycle to the shared 64-bit adder used as a
// comparator. The table contents are undefined after reset and need no
// clearing pass, since only entries below the thread count are ever used. A
// finished result waits in the output register while the next request can
// already be accepted.
module round_robin_sleep_scheduler_core #(
	parameter int unsigned MAX_THREADS = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// [63:0] now, [127:64] sleep_ticks
	input  wire logic [127:0] s_tdata,
	// [1:0] kind
	input  wire logic [1:0]   s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// [2:0] status, [6:3] running_index, [38:7] running_pid, [70:39] new_pid,
	// [71] zero
	output logic      [71:0]  m_tdata
);

	import rrss_pkg::*;

	localparam int unsigned IW = $clog2(MAX_THREADS);
	localparam int unsigned CW = $clog2(MAX_THREADS + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CREATE,
		ST_SLEEP,
		ST_SCAN,
		ST_EXIT,
		ST_EXIT_WR,
		ST_PID_RD,
		ST_DONE
	} state_t;

	state_t            st_q;
	logic [TIME_W-1:0] now_q;
	logic [TIME_W-1:0] ticks_q;
	status_t           status_q;
	logic [PID_W-1:0]  npid_q;
	logic [CW-1:0]     count_q;
	logic [IW-1:0]     run_q;
	logic [PID_W-1:0]  last_q;
	logic [IW-1:0]     scan_t_q;
	logic [CW-1:0]     scan_n_q;
	logic [IW-1:0]     cand_s1;
	logic              cand_v_s1;

	// Output register.
	logic              out_v_q;
	logic [71:0]       out_q;

	// Memory ports and shared adder.
	logic [IW-1:0]     rd_addr;
	logic [IW-1:0]     wr_addr;
	logic              dl_we;
	logic              pid_we;
	logic [TIME_W-1:0] dl_wdata;
	logic [PID_W-1:0]  pid_wdata;
	logic [TIME_W-1:0] dl_rdata;
	logic [PID_W-1:0]  pid_rdata;
	alu_op_t           alu_op;
	logic [TIME_W-1:0] alu_b;
	logic [TIME_W-1:0] alu_sum;
	logic              alu_ge;

	// Round robin successors of the scan pointer and the running index.
	logic [CW-1:0]     scan_inc;
	logic [IW-1:0]     scan_nxt;
	logic [CW-1:0]     run_inc;
	logic [IW-1:0]     run_nxt;
	logic [CW-1:0]     count_dec;
	logic              out_free;
	logic [PID_W-1:0]  run_pid;

	assign scan_inc  = CW'(scan_t_q) + CW'(1);
	assign scan_nxt  = (scan_inc < count_q) ? IW'(scan_inc) : '0;
	assign run_inc   = CW'(run_q) + CW'(1);
	assign run_nxt   = (run_inc < count_q) ? IW'(run_inc) : '0;
	assign count_dec = count_q - CW'(1);
	assign out_free  = !out_v_q || m_tready;
	assign run_pid   = (count_q != '0) ? pid_rdata : '0;

	assign s_tready = (st_q == ST_IDLE);
	assign m_tvalid = out_v_q;
	assign m_tdata  = out_q;

	// Memory and adder steering. By default the pid memory reads the running
	// entry so the result stage always sees its pid.
	always_comb begin
		rd_addr   = run_q;
		wr_addr   = run_q;
		dl_we     = 1'b0;
		pid_we    = 1'b0;
		dl_wdata  = alu_sum;
		pid_wdata = last_q + PID_W'(1);
		alu_op    = ALU_ADD;
		alu_b     = ticks_q;
		case (st_q)
			ST_CREATE: begin
				if (count_q != CW'(MAX_THREADS)) begin
					wr_addr  = IW'(count_q);
					dl_we    = 1'b1;
					pid_we   = 1'b1;
					dl_wdata = '0;
				end
			end
			ST_SLEEP: begin
				dl_we = 1'b1;
			end
			ST_SCAN: begin
				rd_addr = scan_t_q;
				alu_op  = ALU_SUB;
				alu_b   = dl_rdata;
			end
			ST_EXIT: begin
				rd_addr = IW'(count_dec);
			end
			ST_EXIT_WR: begin
				dl_we     = 1'b1;
				pid_we    = 1'b1;
				dl_wdata  = dl_rdata;
				pid_wdata = pid_rdata;
			end
			default: begin
			end
		endcase
	end

	rrss_ram #(
		.WIDTH (TIME_W),
		.DEPTH (MAX_THREADS)
	) u_deadline_ram (
		.clk     (clk),
		.wr_en   (dl_we),
		.wr_addr (wr_addr),
		.wr_data (dl_wdata),
		.rd_addr (rd_addr),
		.rd_data (dl_rdata)
	);

	rrss_ram #(
		.WIDTH (PID_W),
		.DEPTH (MAX_THREADS)
	) u_pid_ram (
		.clk     (clk),
		.wr_en   (pid_we),
		.wr_addr (wr_addr),
		.wr_data (pid_wdata),
		.rd_addr (rd_addr),
		.rd_data (pid_rdata)
	);

	rrss_alu u_alu (
		.op  (alu_op),
		.a   (now_q),
		.b   (alu_b),
		.sum (alu_sum),
		.ge  (alu_ge)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			now_q     <= '0;
			ticks_q   <= '0;
			status_q  <= STAT_OK;
			npid_q    <= '0;
			count_q   <= '0;
			run_q     <= '0;
			last_q    <= '0;
			scan_t_q  <= '0;
			scan_n_q  <= '0;
			cand_s1   <= '0;
			cand_v_s1 <= 1'b0;
			out_v_q   <= 1'b0;
			out_q     <= '0;
		end else begin
			// A new result replaces a taken one in the same cycle.
			if (st_q == ST_DONE && out_free) begin
				out_v_q <= 1'b1;
			end else if (out_v_q && m_tready) begin
				out_v_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						now_q     <= s_tdata[63:0];
						ticks_q   <= s_tdata[127:64];
						npid_q    <= '0;
						scan_t_q  <= run_nxt;
						scan_n_q  <= '0;
						cand_v_s1 <= 1'b0;
						if (kind_t'(s_tuser) == KIND_CREATE) begin
							status_q <= STAT_OK;
							st_q     <= ST_CREATE;
						end else if (count_q == '0) begin
							status_q <= STAT_EMPTY;
							st_q     <= ST_DONE;
						end else begin
							status_q <= STAT_OK;
							case (kind_t'(s_tuser))
								KIND_EXIT:  st_q <= ST_EXIT;
								KIND_SLEEP: st_q <= ST_SLEEP;
								default:    st_q <= ST_SCAN;
							endcase
						end
					end
				end
				ST_CREATE: begin
					if (count_q == CW'(MAX_THREADS)) begin
						status_q <= STAT_FULL;
					end else begin
						count_q <= count_q + CW'(1);
						last_q  <= last_q + PID_W'(1);
						npid_q  <= last_q + PID_W'(1);
					end
					st_q <= ST_PID_RD;
				end
				ST_SLEEP: begin
					// The deadline write lands this cycle; the scan reads it later.
					st_q <= ST_SCAN;
				end
				ST_SCAN: begin
					// One entry is issued to the memory while the previous one is
					// compared against the current time.
					if (scan_n_q != count_q) begin
						scan_t_q  <= scan_nxt;
						scan_n_q  <= scan_n_q + CW'(1);
						cand_s1   <= scan_t_q;
						cand_v_s1 <= 1'b1;
					end else begin
						cand_v_s1 <= 1'b0;
					end
					if (cand_v_s1 && alu_ge) begin
						run_q <= cand_s1;
						st_q  <= ST_PID_RD;
					end else if (cand_v_s1 && scan_n_q == count_q) begin
						status_q <= STAT_NONE_RDY;
						st_q     <= ST_PID_RD;
					end
				end
				ST_EXIT: begin
					count_q <= count_dec;
					if (count_dec == '0) begin
						run_q    <= '0;
						status_q <= STAT_LAST_EXIT;
						st_q     <= ST_DONE;
					end else if (count_dec != CW'(run_q)) begin
						// The highest entry is read now and moved next cycle.
						st_q <= ST_EXIT_WR;
					end else begin
						run_q <= '0;
						st_q  <= ST_PID_RD;
					end
				end
				ST_EXIT_WR: begin
					// The count already holds the reduced value here.
					run_q <= (run_inc == count_q) ? '0 : IW'(run_inc);
					st_q  <= ST_PID_RD;
				end
				ST_PID_RD: begin
					st_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						out_q <= {1'b0, npid_q, run_pid, IDX_W'(run_q), status_q};
						st_q  <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// The running index always points inside the occupied part of the table.
	a_run_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0) |-> (run_q < IW'(count_q - CW'(1)) || run_q == IW'(count_q - CW'(1))))
		else $error("running index beyond thread count");

	// An empty table always reports index zero.
	a_empty_run_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (run_q == '0))
		else $error("running index nonzero with empty table");

	// The thread count moves by at most one per request.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |->
		((count_q == $past(count_q) + CW'(1)) || (count_q == $past(count_q) - CW'(1))))
		else $error("thread count jumped");

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`default_nettype none

module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	import rrss_pkg::*;

	localparam int unsigned MAX_THREADS = 16;
	localparam logic [63:0] TIME_MAX    = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam int unsigned LOOSE_RUN   = 300;

	// One scheduler request as the sender offers it.
	typedef struct packed {
		kind_t       kind;
		logic [63:0] now;
		logic [63:0] ticks;
	} sched_req_t;

	// One scheduler result as the block should report it.
	typedef struct packed {
		status_t     status;
		logic [3:0]  idx;
		logic [31:0] pid;
		logic [31:0] new_pid;
	} sched_outcome_t;

	logic         clk;
	logic         arst_n   = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [127:0] s_tdata  = '0;
	logic [1:0]   s_tuser  = KIND_YIELD;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [71:0]  m_tdata;

	round_robin_sleep_scheduler_core #(
		.MAX_THREADS(MAX_THREADS)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	// Requests waiting to be offered, and the results still owed by the block.
	sched_req_t     req_q[$];
	sched_outcome_t outcome_q[$];

	// Shadow copy of the thread table, kept in step with accepted requests.
	logic [63:0] tbl_deadline [MAX_THREADS];
	logic [31:0] tbl_pid      [MAX_THREADS];
	int unsigned thr_count = 0;
	int unsigned run_slot  = 0;
	logic [31:0] pid_ctr   = '0;

	// Pacing knobs, set by the sequence only at a falling edge so the clocked
	// processes never race with those writes.
	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned recv_hold      = 0;

	// Generator state: a rough thread count, the count it drifts toward and
	// a running clock so that deadlines land close to the current time.
	int unsigned gen_count  = 0;
	int unsigned gen_target = 0;
	logic [63:0] gen_now    = '0;

	int unsigned sent_cnt     = 0;
	int unsigned checked_cnt  = 0;
	int unsigned mismatch_cnt = 0;
	int unsigned stat_hits [5] = '{default: 0};

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Generous bound: far beyond the slowest legal pacing of every request.
	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// Apply one accepted request to the shadow table and queue the result the
	// block owes for it. The scan visits each entry at most once, starting after the
	// running one, and stops at the first ready entry or on the running entry itself.
	task automatic schedule_event(input kind_t kind, input logic [63:0] now,
			input logic [63:0] ticks);
		sched_outcome_t res;
		int unsigned    t;
		int unsigned    cur;
		logic           found;
		res = '{status: STAT_OK, idx: '0, pid: '0, new_pid: '0};
		if (kind == KIND_CREATE) begin
			if (thr_count >= MAX_THREADS) begin
				res.status = STAT_FULL;
			end else begin
				pid_ctr                 = pid_ctr + 32'd1;
				tbl_pid[thr_count]      = pid_ctr;
				tbl_deadline[thr_count] = '0;
				thr_count++;
				res.new_pid = pid_ctr;
			end
		end else if (thr_count == 0) begin
			// Nothing to run: the state stays as it is.
			res.status = STAT_EMPTY;
		end else if (kind == KIND_EXIT) begin
			cur = run_slot;
			thr_count--;
			if (thr_count == 0) begin
				run_slot   = 0;
				res.status = STAT_LAST_EXIT;
			end else if (thr_count != cur) begin
				// The highest entry fills the hole left by the exiting thread.
				tbl_pid[cur]      = tbl_pid[thr_count];
				tbl_deadline[cur] = tbl_deadline[thr_count];
				run_slot          = (cur + 1) % thr_count;
			end else begin
				run_slot = 0;
			end
		end else begin
			if (kind == KIND_SLEEP)
				tbl_deadline[run_slot] = now + ticks;
			res.status = STAT_NONE_RDY;
			t          = run_slot;
			found      = 1'b0;
			for (int unsigned n = 0; n < thr_count; n++) begin
				if (!found) begin
					t = (t + 1 < thr_count) ? t + 1 : 0;
					if (now >= tbl_deadline[t]) begin
						run_slot   = t;
						found      = 1'b1;
						res.status = STAT_OK;
					end
				end
			end
		end
		res.idx = run_slot[3:0];
		res.pid = (thr_count != 0) ? tbl_pid[run_slot] : '0;
		outcome_q.push_back(res);
	endtask

	// Queue one request and keep the generator's idea of the count current.
	task automatic push_req(input kind_t kind, input logic [63:0] now,
			input logic [63:0] ticks);
		req_q.push_back('{kind: kind, now: now, ticks: ticks});
		if (kind == KIND_CREATE && gen_count < MAX_THREADS)
			gen_count++;
		else if (kind == KIND_EXIT && gen_count > 0)
			gen_count--;
	endtask

	// Random requests. Most of them follow a thread count that wanders
	// between empty and full, with sleeps and yields against a clock that
	// creeps forward, so deadlines are often just ahead of or just behind
	// the time. A share of kinds and times are pure noise.
	task automatic queue_random(input int unsigned n);
		int unsigned roll;
		kind_t       kind;
		logic [63:0] ticks;
		for (int unsigned i = 0; i < n; i++) begin
			if ($urandom_range(47) == 0)
				gen_target = $urandom_range(MAX_THREADS);
			roll = $urandom_range(99);
			if (roll < 40 && (gen_count < gen_target || gen_target == MAX_THREADS))
				kind = KIND_CREATE;
			else if (roll < 40 && gen_count > gen_target)
				kind = KIND_EXIT;
			else if (roll < 50)
				kind = kind_t'($urandom_range(3));
			else if (roll < 78)
				kind = KIND_SLEEP;
			else
				kind = KIND_YIELD;

			roll = $urandom_range(99);
			if (roll < 4)
				gen_now = {$urandom, $urandom};
			else if (roll < 7)
				gen_now = TIME_MAX - 64'($urandom_range(40));
			else if (roll < 90)
				gen_now = gen_now + 64'($urandom_range(12));

			roll = $urandom_range(99);
			if (roll < 75)
				ticks = 64'($urandom_range(30));
			else if (roll < 92)
				ticks = {$urandom, $urandom};
			else
				ticks = TIME_MAX - 64'($urandom_range(20));
			push_req(kind, gen_now, ticks);
		end
	endtask

	// Block until the sender has nothing left and every result has come.
	task automatic wait_drained();
		while (req_q.size() != 0 || s_tvalid || outcome_q.size() != 0)
			@(posedge clk);
	endtask

	// Sender. A request stays on the bus until it is taken; the shadow table
	// is updated from the bus itself at the edge of acceptance.
	always @(posedge clk or negedge arst_n) begin
		sched_req_t req;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= KIND_YIELD;
		end else begin
			if (s_tvalid && s_tready) begin
				schedule_event(kind_t'(s_tuser), s_tdata[63:0], s_tdata[127:64]);
				sent_cnt++;
			end
			if (!s_tvalid || s_tready) begin
				if (req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					req      = req_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {req.ticks, req.now};
					s_tuser  <= req.kind;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver. Each result taken is checked against the oldest one owed.
	// A hold request keeps tready low for a counted stretch.
	always @(posedge clk or negedge arst_n) begin
		sched_outcome_t want;
		logic [2:0]     got_status;
		logic [3:0]     got_idx;
		logic [31:0]    got_pid;
		logic [31:0]    got_new_pid;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got_status  = m_tdata[2:0];
				got_idx     = m_tdata[6:3];
				got_pid     = m_tdata[38:7];
				got_new_pid = m_tdata[70:39];
				checked_cnt++;
				if (got_status < 5)
					stat_hits[got_status]++;
				if (outcome_q.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("[%0t] result with none owed: status %0d idx %0d pid %0d new %0d",
							$realtime, got_status, got_idx, got_pid, got_new_pid);
				end else begin
					want = outcome_q.pop_front();
					if (got_status != want.status || got_idx != want.idx ||
							got_pid != want.pid || got_new_pid != want.new_pid) begin
						mismatch_cnt++;
						if (mismatch_cnt <= 10)
							$display({"[%0t] result %0d: status %0d/%0d idx %0d/%0d ",
								"pid %0d/%0d new %0d/%0d (want/got)"},
								$realtime, checked_cnt, want.status, got_status,
								want.idx, got_idx, want.pid, got_pid,
								want.new_pid, got_new_pid);
					end
				end
			end
			if (recv_hold > 0) begin
				recv_hold--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	initial begin
		gen_now = {$urandom, $urandom};
		@(posedge arst_n);

		// Directed opening: every kind on an empty table, a sleep that finds
		// nothing ready, a wake exactly at the deadline, the last thread
		// exiting, then the table filled to the brim and one create too many,
		// and an exit from the bottom that pulls the highest entry down.
		push_req(KIND_YIELD, '0, '0);
		push_req(KIND_SLEEP, TIME_MAX, TIME_MAX);
		push_req(KIND_EXIT, TIME_MAX, '0);
		push_req(KIND_CREATE, '0, '0);
		push_req(KIND_SLEEP, 64'd100, 64'd50);
		push_req(KIND_YIELD, 64'd150, '0);
		push_req(KIND_EXIT, 64'd150, '0);
		for (int unsigned i = 0; i <= MAX_THREADS; i++)
			push_req(KIND_CREATE, 64'(i), TIME_MAX);
		push_req(KIND_EXIT, '0, '0);

		// No idling at all, but the receiver first holds off for a long
		// stretch while requests keep coming, so the block backs up.
		queue_random(LOOSE_RUN);
		@(negedge clk);
		recv_hold = 300;
		wait_drained();

		// Sender mostly idle.
		@(negedge clk);
		send_idle_pct = 86;
		queue_random(LOOSE_RUN);
		wait_drained();

		// Receiver mostly stalling.
		@(negedge clk);
		send_idle_pct  = 0;
		recv_stall_pct = 86;
		queue_random(LOOSE_RUN);
		wait_drained();

		// Light idling on both sides.
		@(negedge clk);
		send_idle_pct  = 18;
		recv_stall_pct = 18;
		queue_random(LOOSE_RUN);
		wait_drained();

		repeat (40) @(posedge clk);
		if (outcome_q.size() != 0)
			mismatch_cnt++;

		$display("Ran %0d scheduler requests across four pacing phases, %0d results checked.",
			sent_cnt, checked_cnt);
		$display("By status: ok %0d, none ready %0d, full %0d, empty %0d, last exit %0d.",
			stat_hits[0], stat_hits[1], stat_hits[2], stat_hits[3], stat_hits[4]);
		if (mismatch_cnt == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire
